// File: hw/rtl/nns_pkg.sv
// Shared types and constants of the nearest-neighbor scaler.
// No dependencies; imported by the scaler top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

	// Fixed field widths of the item and result ports.
	localparam int POS_W      = 10;
	localparam int CH_W       = 8;
	localparam int COORD_W    = 8;

	// Configuration port and register widths.
	localparam int SRC_CFG_W  = 9;
	localparam int DST_CFG_W  = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Register values after reset.
	localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST  = 9'd256;
	localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST = 9'd256;
	localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST  = 11'd256;
	localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 11'd256;

	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_FETCH = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pix_t;

endpackage

`default_nettype wire

// File: hw/rtl/nearest_neighbour_scaler.sv
// Nearest-neighbor image scaler: frame store, scaling pipeline and config registers.
// Depends on nns_pkg and instantiates nns_div twice (column and row).
//
// Usage: the block takes one item per clock whenever busy is low; busy is high
// only in the first cycle after reset. A load (mode 0) writes one RGB pixel into
// the frame store at (pos_x, pos_y); a load outside the configured source size
// is dropped and gives no result. A fetch (mode 1) names a destination pixel,
// and the block returns the source pixel at floor(pos * src / dst) in each
// axis, clamped to the last source column or row, together with those source
// coordinates. Results come out strictly in order, one per fetch, each shown for
// exactly one cycle with done high; there is no way to stall them, so the
// receiver must take every transfer as it comes. Fetches pass through pipelined
// restoring dividers, which resolve one quotient bit per stage; loads travel
// the same pipeline and write the store at the stage where fetches read it, so
// a fetch always sees every load transferred before it. The frame store is a
// single memory of MAX_SRC_WIDTH * MAX_SRC_HEIGHT 24-bit words with a fixed
// row stride of MAX_SRC_WIDTH; it is not cleared, and a pixel fetched before it
// was ever loaded reads as whatever the memory holds. Size registers must be
// written through the cfg channel only while no item of either kind is in
// flight; the block itself does not enforce it. A size of zero acts as one and
// a size above the maximum saturates to the maximum.

`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbour_scaler #(
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int MAX_DST_SIZE   = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            start,
	output logic                            busy,
	input  logic                            mode,
	input  logic [nns_pkg::POS_W-1:0]       pos_x,
	input  logic [nns_pkg::POS_W-1:0]       pos_y,
	input  logic [nns_pkg::CH_W-1:0]        in_red,
	input  logic [nns_pkg::CH_W-1:0]        in_green,
	input  logic [nns_pkg::CH_W-1:0]        in_blue,

	output logic                            done,
	output logic [nns_pkg::CH_W-1:0]        out_red,
	output logic [nns_pkg::CH_W-1:0]        out_green,
	output logic [nns_pkg::CH_W-1:0]        out_blue,
	output logic [nns_pkg::COORD_W-1:0]     src_col,
	output logic [nns_pkg::COORD_W-1:0]     src_row,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nns_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nns_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import nns_pkg::*;

	// Index widths of the store and of the scaled coordinates.
	localparam int CW    = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
	localparam int RW    = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
	localparam int QW    = (CW > RW) ? CW : RW;
	// Widths of the saturated sizes.
	localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int DWW   = $clog2(MAX_DST_SIZE + 1);
	// Widths of the scaled numerators pos * src.
	localparam int NXW   = POS_W + SWW;
	localparam int NYW   = POS_W + SHW;
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	// Edges from an accepted item to the edge that first samples its done.
	localparam int LATENCY = QW + 4;

	// Sideband that travels alongside the dividers. The valid bits travel
	// beside it in registers of their own, since only they are reset.
	typedef struct packed {
		logic          fetch;
		logic          wr;
		logic          clx;
		logic          cly;
		logic [CW-1:0] lcol;
		logic [RW-1:0] lrow;
		pix_t          pix;
	} side_t;

	// ------------------------------------------------------------------
	// Start-up and configuration registers
	// ------------------------------------------------------------------
	logic                 run_q;
	logic [SRC_CFG_W-1:0] src_width_q;
	logic [SRC_CFG_W-1:0] src_height_q;
	logic [DST_CFG_W-1:0] dst_width_q;
	logic [DST_CFG_W-1:0] dst_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign busy      = !run_q;
	assign cfg_ready = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_WIDTH_RST;
			src_height_q <= SRC_HEIGHT_RST;
			dst_width_q  <= DST_WIDTH_RST;
			dst_height_q <= DST_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_CFG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_CFG_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DST_CFG_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DST_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturated sizes. Configuration must change only while the pipeline is empty, so
	// every stage may use these directly; the block itself does not enforce that.
	logic [SWW-1:0] sw;
	logic [SHW-1:0] sh;
	logic [DWW-1:0] dw;
	logic [DWW-1:0] dh;

	always_comb begin
		if (src_width_q == '0) begin
			sw = SWW'(1);
		end else if (32'(src_width_q) > MAX_SRC_WIDTH) begin
			sw = SWW'(MAX_SRC_WIDTH);
		end else begin
			sw = SWW'(src_width_q);
		end

		if (src_height_q == '0) begin
			sh = SHW'(1);
		end else if (32'(src_height_q) > MAX_SRC_HEIGHT) begin
			sh = SHW'(MAX_SRC_HEIGHT);
		end else begin
			sh = SHW'(src_height_q);
		end

		if (dst_width_q == '0) begin
			dw = DWW'(1);
		end else if (32'(dst_width_q) > MAX_DST_SIZE) begin
			dw = DWW'(MAX_DST_SIZE);
		end else begin
			dw = DWW'(dst_width_q);
		end

		if (dst_height_q == '0) begin
			dh = DWW'(1);
		end else if (32'(dst_height_q) > MAX_DST_SIZE) begin
			dh = DWW'(MAX_DST_SIZE);
		end else begin
			dh = DWW'(dst_height_q);
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the transferred item
	// ------------------------------------------------------------------
	logic             acc;
	logic             vld_s1;
	logic             fetch_s1;
	logic [POS_W-1:0] px_s1;
	logic [POS_W-1:0] py_s1;
	pix_t             pix_s1;

	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fetch_s1 <= (mode == MODE_FETCH);
			px_s1    <= pos_x;
			py_s1    <= pos_y;
			pix_s1   <= '{red: in_red, green: in_green, blue: in_blue};
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: numerators, clamp decisions and load bounds check
	// ------------------------------------------------------------------
	side_t          side_s2;
	logic           vld_s2;
	logic [NXW-1:0] numx_s2;
	logic [NYW-1:0] numy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// A destination coordinate at or beyond the destination size maps to a
	// quotient of at least the source size, so it clamps to the last index.
	// Below that the quotient fits the index width and the divider is exact.
	always_ff @(posedge clk) begin
		side_s2.fetch <= fetch_s1;
		side_s2.wr    <= !fetch_s1 && (32'(px_s1) < 32'(sw)) && (32'(py_s1) < 32'(sh));
		side_s2.clx   <= (32'(px_s1) >= 32'(dw));
		side_s2.cly   <= (32'(py_s1) >= 32'(dh));
		side_s2.lcol  <= CW'(px_s1);
		side_s2.lrow  <= RW'(py_s1);
		side_s2.pix   <= pix_s1;
		numx_s2       <= NXW'(px_s1) * NXW'(sw);
		numy_s2       <= NYW'(py_s1) * NYW'(sh);
	end

	// ------------------------------------------------------------------
	// Stage 3: QW divider stages, sideband delayed to match
	// ------------------------------------------------------------------
	logic [QW-1:0] quox;
	logic [QW-1:0] quoy;

	nns_div #(
		.NUM_W (NXW),
		.DEN_W (DWW),
		.QUO_W (QW)
	) u_div_col (
		.clk (clk),
		.num (numx_s2),
		.den (dw),
		.quo (quox)
	);

	nns_div #(
		.NUM_W (NYW),
		.DEN_W (DWW),
		.QUO_W (QW)
	) u_div_row (
		.clk (clk),
		.num (numy_s2),
		.den (dh),
		.quo (quoy)
	);

	// Element k is the sideband and valid bit after divider stage k.
	side_t side_s3 [QW];
	logic  vld_s3 [QW];

	for (genvar k = 0; k < QW; k++) begin : g_side
		side_t sin;
		logic  vin;

		if (k == 0) begin : g_first
			assign sin = side_s2;
			assign vin = vld_s2;
		end else begin : g_next
			assign sin = side_s3[k-1];
			assign vin = vld_s3[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k] <= 1'b0;
			end else begin
				vld_s3[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			side_s3[k] <= sin;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: final coordinates and store address
	// ------------------------------------------------------------------
	side_t         side_dv;
	logic [CW-1:0] col_c;
	logic [RW-1:0] row_c;
	logic          vld_s4;
	logic          fetch_s4;
	logic          wr_s4;
	logic [AW-1:0] addr_s4;
	logic [CW-1:0] col_s4;
	logic [RW-1:0] row_s4;
	pix_t          pix_s4;

	assign side_dv = side_s3[QW-1];

	always_comb begin
		if (!side_dv.fetch) begin
			col_c = side_dv.lcol;
			row_c = side_dv.lrow;
		end else begin
			col_c = side_dv.clx ? CW'(sw - SWW'(1)) : CW'(quox);
			row_c = side_dv.cly ? RW'(sh - SHW'(1)) : RW'(quoy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			wr_s4  <= 1'b0;
		end else begin
			vld_s4 <= vld_s3[QW-1];
			wr_s4  <= vld_s3[QW-1] && side_dv.wr;
		end
	end

	always_ff @(posedge clk) begin
		fetch_s4 <= side_dv.fetch;
		addr_s4  <= AW'(32'(row_c) * MAX_SRC_WIDTH + 32'(col_c));
		col_s4   <= col_c;
		row_s4   <= row_c;
		pix_s4   <= side_dv.pix;
	end

	// ------------------------------------------------------------------
	// Stage 5: frame store access and result
	// ------------------------------------------------------------------
	// Loads and fetches reach the store in transfer order, one per cycle, so even a
	// fetch right behind a load to the same pixel reads the new value.
	pix_t          frame_store [DEPTH];
	pix_t          rd_s5;
	logic          done_s5;
	logic [CW-1:0] col_s5;
	logic [RW-1:0] row_s5;

	always_ff @(posedge clk) begin
		if (wr_s4) begin
			frame_store[addr_s4] <= pix_s4;
		end
		rd_s5 <= frame_store[addr_s4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= vld_s4 && fetch_s4;
		end
	end

	always_ff @(posedge clk) begin
		col_s5 <= col_s4;
		row_s5 <= row_s4;
	end

	assign done      = done_s5;
	assign out_red   = rd_s5.red;
	assign out_green = rd_s5.green;
	assign out_blue  = rd_s5.blue;
	assign src_col   = COORD_W'(col_s5);
	assign src_row   = COORD_W'(row_s5);

endmodule

`default_nettype wire

// File: hw/rtl/nns_div.sv
// Pipelined restoring divider: one quotient bit per stage, QUO_W stages.
// Standalone; used by the scaler top level for the column and row scaling.
`timescale 1ns / 1ps
`default_nettype none

module nns_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 11,
	parameter int QUO_W = 8
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	// Wide enough for the numerator and for the divisor at its largest shift.
	localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

	logic [CMP_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int BIT = QUO_W - 1 - k;

		logic [CMP_W-1:0] rin;
		logic [QUO_W-1:0] qin;
		logic [CMP_W-1:0] dsh;
		logic             ge;
		logic [QUO_W-1:0] qn;

		if (k == 0) begin : g_first
			assign rin = CMP_W'(num);
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign qin = quo_s[k-1];
		end

		assign dsh = CMP_W'(den) << BIT;
		assign ge  = (rin >= dsh);

		always_comb begin
			qn      = qin;
			qn[BIT] = ge;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? (rin - dsh) : rin;
			quo_s[k] <= qn;
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/nns_chk.sv
// Port-level checker for the nearest-neighbor scaler, with its bind statement.
// Depends on nns_pkg; attaches to nearest_neighbour_scaler.
`timescale 1ns / 1ps
`default_nettype none

module nns_chk #(
	parameter int LATENCY = 12
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         mode,
	input wire logic [nns_pkg::POS_W-1:0]    pos_x,
	input wire logic [nns_pkg::POS_W-1:0]    pos_y,
	input wire logic                         done,
	input wire logic [nns_pkg::COORD_W-1:0]  src_col,
	input wire logic [nns_pkg::COORD_W-1:0]  src_row
);

	import nns_pkg::*;

	localparam int AGE_W = $clog2(LATENCY + 1);

	logic             fetch_acc;
	logic [AGE_W-1:0] age_q;
	logic             warm;

	assign fetch_acc = start && !busy && (mode == MODE_FETCH);

	// Counts edges since reset so that look-backs never reach before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (!warm) begin
			age_q <= age_q + AGE_W'(1);
		end
	end

	assign warm = (age_q == AGE_W'(LATENCY));

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done) |-> $past(fetch_acc, LATENCY))
		else $error("result strobe without a fetch transfer at the fixed latency");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(fetch_acc, LATENCY)) |-> done)
		else $error("fetch transfer did not produce a result at the fixed latency");

	a_origin_col: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(fetch_acc && (pos_x == '0), LATENCY)) |-> (src_col == '0))
		else $error("destination column zero did not map to source column zero");

	a_origin_row: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && $past(fetch_acc && (pos_y == '0), LATENCY)) |-> (src_row == '0))
		else $error("destination row zero did not map to source row zero");

endmodule

bind nearest_neighbour_scaler nns_chk #(.LATENCY(LATENCY)) u_nns_chk (.*);

`default_nettype wire

// File: tb/nearest_neighbour_scaler_tb.sv
// Self-checking testbench of the nearest-neighbor scaler: directed corner items, then random
// load and fetch traffic over several source and destination sizes, checked by a scoreboard.
// Depends on nns_pkg and the nearest_neighbour_scaler top level.
`timescale 1ns / 1ps

module nearest_neighbour_scaler_tb;

	import nns_pkg::*;

	// Geometry of the instance under test; the scoreboard keeps a store of the same shape.
	localparam int STORE_COLS      = 256;
	localparam int STORE_ROWS      = 256;
	localparam int DST_MAX         = 1024;

	localparam int RESET_CYCLES    = 4;
	localparam int MAX_GAP         = 8;
	// Loads give no result, so after the last result the pipeline may still hold loads.
	// The drain lets them leave the pipeline, with some margin.
	localparam int DRAIN_CYCLES    = 16;
	// The longest correct stretch with no transfer of any kind is no longer than a drain plus a gap.
	localparam int WATCHDOG_LIMIT  = 500;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 192;

	// Indexes 4 to 7 are not decoded by the block; writes there must have no effect.
	localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd4;

	// One fetch result: the sampled pixel and the clamped source coordinates.
	typedef struct packed {
		pix_t                 pix;
		logic [COORD_W-1:0]   col;
		logic [COORD_W-1:0]   row;
	} sample_t;

	// The scoreboard holds its own copy of the size registers and the frame store. Every
	// accepted load updates the store, every accepted fetch queues the sample it must return,
	// and every result is matched against the oldest queued sample.
	class pixel_scoreboard;
		logic [SRC_CFG_W-1:0] src_w_reg;
		logic [SRC_CFG_W-1:0] src_h_reg;
		logic [DST_CFG_W-1:0] dst_w_reg;
		logic [DST_CFG_W-1:0] dst_h_reg;
		pix_t                 frame [STORE_COLS*STORE_ROWS];
		bit                   loaded [STORE_COLS*STORE_ROWS];
		sample_t              expected_q [$];
		int                   errors;

		function new();
			src_w_reg = SRC_WIDTH_RST;
			src_h_reg = SRC_HEIGHT_RST;
			dst_w_reg = DST_WIDTH_RST;
			dst_h_reg = DST_HEIGHT_RST;
			errors    = 0;
		endfunction

		// A size of zero acts as one; anything above the maximum saturates.
		function int unsigned clip_size(int unsigned v, int unsigned max);
			if (v == 0)
				return 1;
			return (v > max) ? max : v;
		endfunction

		function int unsigned src_cols();
			return clip_size(src_w_reg, STORE_COLS);
		endfunction

		function int unsigned src_rows();
			return clip_size(src_h_reg, STORE_ROWS);
		endfunction

		function int unsigned dst_cols();
			return clip_size(dst_w_reg, DST_MAX);
		endfunction

		function int unsigned dst_rows();
			return clip_size(dst_h_reg, DST_MAX);
		endfunction

		// floor(pos * src / dst), held to the last source column or row.
		function int unsigned map_coord(int unsigned pos, int unsigned src, int unsigned dst);
			int unsigned s;
			s = (pos * src) / dst;
			return (s > src - 1) ? src - 1 : s;
		endfunction

		function bit is_loaded(int unsigned col, int unsigned row);
			return loaded[row * STORE_COLS + col];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SRC_WIDTH:  src_w_reg = data[SRC_CFG_W-1:0];
				REG_SRC_HEIGHT: src_h_reg = data[SRC_CFG_W-1:0];
				REG_DST_WIDTH:  dst_w_reg = data[DST_CFG_W-1:0];
				REG_DST_HEIGHT: dst_h_reg = data[DST_CFG_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(mode_t m, int unsigned x, int unsigned y, pix_t p);
			sample_t     s;
			int unsigned col;
			int unsigned row;
			if (m == MODE_LOAD) begin
				// Loads outside the current source size are dropped by the block.
				if (x < src_cols() && y < src_rows()) begin
					frame[y * STORE_COLS + x]  = p;
					loaded[y * STORE_COLS + x] = 1'b1;
				end
			end else begin
				col   = map_coord(x, src_cols(), dst_cols());
				row   = map_coord(y, src_rows(), dst_rows());
				s.pix = frame[row * STORE_COLS + col];
				s.col = col[COORD_W-1:0];
				s.row = row[COORD_W-1:0];
				expected_q.push_back(s);
			end
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(pix_t p, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
			sample_t s;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no fetch outstanding, expected none, actual col %0d row %0d",
					$time, col, row);
				return;
			end
			s = expected_q.pop_front();
			if (p.red !== s.pix.red)
				report("out_red", s.pix.red, p.red);
			if (p.green !== s.pix.green)
				report("out_green", s.pix.green, p.green);
			if (p.blue !== s.pix.blue)
				report("out_blue", s.pix.blue, p.blue);
			if (col !== s.col)
				report("src_col", s.col, col);
			if (row !== s.row)
				report("src_row", s.row, row);
		endfunction
	endclass

	// Every input starts at a known value; reset is held from time zero.
	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic                  mode      = 1'b0;
	logic [POS_W-1:0]      pos_x     = '0;
	logic [POS_W-1:0]      pos_y     = '0;
	logic [CH_W-1:0]       in_red    = '0;
	logic [CH_W-1:0]       in_green  = '0;
	logic [CH_W-1:0]       in_blue   = '0;
	logic                  done;
	logic [CH_W-1:0]       out_red;
	logic [CH_W-1:0]       out_green;
	logic [CH_W-1:0]       out_blue;
	logic [COORD_W-1:0]    src_col;
	logic [COORD_W-1:0]    src_row;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pixel_scoreboard sb;
	int              quiet_cycles = 0;

	nearest_neighbour_scaler #(
		.MAX_SRC_WIDTH  (STORE_COLS),
		.MAX_SRC_HEIGHT (STORE_ROWS),
		.MAX_DST_SIZE   (DST_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.done      (done),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.src_col   (src_col),
		.src_row   (src_row),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Results cannot be stalled, so each cycle with done high is one transfer to be checked.
	// Outputs are sampled at the edge, before the block updates them.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(pix_t'({out_red, out_green, out_blue}), src_col, src_row);
	end

	// The watchdog restarts on any transfer: an item, a result or a register write. A block
	// that stops answering or stops taking items ends the run here.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Presents one item and holds it until the block takes it. An item is transferred at an
	// edge where start is high and busy is low; busy is read at the edge itself, so it still
	// holds its value from the cycle that ends there. With no gap, start simply stays high and
	// the next item follows at once; otherwise start drops for a random gap first.
	task automatic send_item(mode_t m, int unsigned x, int unsigned y, pix_t p, bit idle_on);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		mode     <= m;
		pos_x    <= x[POS_W-1:0];
		pos_y    <= y[POS_W-1:0];
		in_red   <= p.red;
		in_green <= p.green;
		in_blue  <= p.blue;
		do @(posedge clk); while (busy);
		sb.note_item(m, x, y, p);
	endtask

	// Stops issuing items and waits until every fetch has returned and the loads behind the
	// last one have also left the pipeline.
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all four size registers back to back, then one undecoded index with random data.
	// Valid stays high across the writes so it never toggles within one edge.
	task automatic configure(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
		logic [CFG_DATA_W-1:0] dw, logic [CFG_DATA_W-1:0] dh);
		logic [CFG_DATA_W-1:0] vals [4];
		reg_idx_t              ids [4];
		vals = '{sw, sh, dw, dh};
		ids  = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_DST_WIDTH, REG_DST_HEIGHT};
		wait_idle();
		cfg_valid <= 1'b1;
		for (int i = 0; i <= 4; i++) begin
			if (i < 4) begin
				cfg_index <= ids[i];
				cfg_data  <= vals[i];
			end else begin
				cfg_index <= FIRST_SPARE_REG | CFG_IDX_W'($urandom_range(0, 3));
				cfg_data  <= CFG_DATA_W'($urandom);
			end
			do @(posedge clk); while (!cfg_ready);
			sb.note_config(cfg_index, cfg_data);
		end
		cfg_valid <= 1'b0;
	endtask

	// One random item. Half are loads, mostly inside the source image; half are fetches,
	// mostly inside the destination image. A fetch that would land on a pixel never loaded
	// becomes a load of that very pixel instead, so the store fills where it is read.
	task automatic random_item(bit idle_on);
		int unsigned x;
		int unsigned y;
		int unsigned col;
		int unsigned row;
		logic [31:0] colour;
		mode_t       m;
		colour = $urandom;
		if ($urandom_range(0, 1) == 0) begin
			m = MODE_LOAD;
			if ($urandom_range(0, 4) != 0) begin
				x = $urandom_range(0, sb.src_cols() - 1);
				y = $urandom_range(0, sb.src_rows() - 1);
			end else begin
				x = $urandom_range(0, DST_MAX - 1);
				y = $urandom_range(0, DST_MAX - 1);
			end
		end else begin
			m = MODE_FETCH;
			if ($urandom_range(0, 6) != 0) begin
				x = $urandom_range(0, sb.dst_cols() - 1);
				y = $urandom_range(0, sb.dst_rows() - 1);
			end else begin
				x = $urandom_range(0, DST_MAX - 1);
				y = $urandom_range(0, DST_MAX - 1);
			end
			col = sb.map_coord(x, sb.src_cols(), sb.dst_cols());
			row = sb.map_coord(y, sb.src_rows(), sb.dst_rows());
			if (!sb.is_loaded(col, row)) begin
				m = MODE_LOAD;
				x = col;
				y = row;
			end
		end
		send_item(m, x, y, pix_t'(colour[23:0]), idle_on);
	endtask

	initial begin
		int unsigned sw;
		int unsigned sh;
		int unsigned dw;
		int unsigned dh;
		bit          idle_on;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes, 256 by 256 both ways. Load the four corners, try loads just past the
		// source edge and at the far end of the coordinate range, then fetch the corners,
		// including destination pixels far outside the image that clamp to the last row
		// or column.
		send_item(MODE_LOAD, 0, 0, 24'h000000, 1'b1);
		send_item(MODE_LOAD, 255, 255, 24'hFFFFFF, 1'b1);
		send_item(MODE_LOAD, 255, 0, 24'hA5A5A5, 1'b1);
		send_item(MODE_LOAD, 0, 255, 24'h5A5A5A, 1'b1);
		send_item(MODE_LOAD, 256, 0, 24'h0F0F0F, 1'b1);
		send_item(MODE_LOAD, 0, 256, 24'hF0F0F0, 1'b1);
		send_item(MODE_LOAD, 1023, 1023, 24'hFFFFFF, 1'b1);
		send_item(MODE_FETCH, 0, 0, 24'hFFFFFF, 1'b1);
		send_item(MODE_FETCH, 255, 255, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 1023, 1023, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 1023, 0, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 0, 1023, 24'h000000, 1'b1);

		// Zero source sizes act as one pixel; 2047 destination sizes saturate to 1024.
		configure(0, 0, 11'h7FF, 11'h7FF);
		send_item(MODE_LOAD, 1, 0, 24'hC3C3C3, 1'b1);
		send_item(MODE_LOAD, 0, 0, 24'h123456, 1'b1);
		send_item(MODE_FETCH, 1023, 1023, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 0, 0, 24'h000000, 1'b1);

		// Source sizes with every data bit set saturate to 256; zero destination sizes act
		// as one, so any coordinate above zero maps to the last source column or row. The
		// store keeps its stride, so the corners loaded earlier are still in place.
		configure(11'h7FF, 11'h7FF, 0, 0);
		send_item(MODE_FETCH, 0, 0, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 1, 1, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 1, 0, 24'h000000, 1'b1);
		send_item(MODE_FETCH, 0, 1023, 24'h000000, 1'b1);

		// Random traffic, one size setting per phase: the extremes first, then random sizes
		// with an occasional out-of-range register value. Every third phase runs without gaps.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(256, 256, 1024, 1024);
				1: configure(1, 1, 1, 1);
				2: configure(256, 1, 1, 1024);
				3: configure(0, 11'h7FF, 11'h7FF, 0);
				4: configure(1, 256, 1024, 1);
				default: begin
					sw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 256);
					sh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 256);
					dw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
					dh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
					configure(sw[CFG_DATA_W-1:0], sh[CFG_DATA_W-1:0], dw[CFG_DATA_W-1:0],
						dh[CFG_DATA_W-1:0]);
				end
			endcase
			idle_on = (phase % 3 != 1);
			repeat (ITEMS_PER_PHASE) random_item(idle_on);
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
